@@ rtl/drls_pkg.sv @@
// shared types, codes and constants for the dds register load sequencer
package drls_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned FREQ_W     = 28;
  localparam int unsigned PHASE_W    = 12;
  localparam int unsigned HALF_W     = 14;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned REG_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_F0   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_F0P0 = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_ALL  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RAW       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CTRL      = 3'd4;

  // register indexes
  localparam logic [1:0] REG_FREQ0  = 2'd0;
  localparam logic [1:0] REG_PHASE0 = 2'd1;
  localparam logic [1:0] REG_FREQ1  = 2'd2;
  localparam logic [1:0] REG_PHASE1 = 2'd3;

  // frame words and tags
  localparam logic [WORD_W-1:0] CTRL_SQW_ON  = 16'h2328;
  localparam logic [WORD_W-1:0] CTRL_SQW_OFF = 16'h2308;
  localparam logic [WORD_W-1:0] TAG_FREQ0    = 16'h4000;
  localparam logic [WORD_W-1:0] TAG_FREQ1    = 16'h8000;
  localparam logic [WORD_W-1:0] TAG_PHASE0   = 16'hC000;
  localparam logic [WORD_W-1:0] TAG_PHASE1   = 16'hE000;

  typedef enum logic [1:0] {
    OP_LOAD_F0,
    OP_LOAD_F0P0,
    OP_LOAD_ALL,
    OP_SINGLE
  } drls_op_e;

  typedef struct packed {
    drls_op_e            op;
    logic [WORD_W-1:0]   word;
  } drls_entry_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   freq0;
    logic [PHASE_W-1:0]  phase0;
    logic [FREQ_W-1:0]   freq1;
    logic [PHASE_W-1:0]  phase1;
  } drls_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic                reset_pulse;
    logic                last;
  } drls_item_t;

endpackage

@@ rtl/drls_if.sv @@
// handshake channel interfaces for commands and frame items
interface drls_cmd_if import drls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [WORD_W-1:0]   raw_word;
  logic                square_enable;

  modport source (output valid, func, raw_word, square_enable, input ready);
  modport sink   (input valid, func, raw_word, square_enable, output ready);
endinterface

interface drls_item_if import drls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   word;
  logic                reset_pulse;
  logic                last;

  modport source (output valid, word, reset_pulse, last, input ready);
  modport sink   (input valid, word, reset_pulse, last, output ready);
endinterface

@@ rtl/dds_register_load_sequencer_unit.sv @@
// top level of the dds register load sequencer
// Turns one host command into the ordered frame items for a direct digital
// synthesizer: each item is either a 16-bit word to shift out msb first or a
// pulse on the device reset pin, and the final item of a command carries last.
// Load-all sends 0x2308, a reset pulse, the low and high 14-bit halves of
// frequency word 0 (tag 0x4000) and word 1 (tag 0x8000), then phase 0 (tag
// 0xC000) and phase 1 (tag 0xE000); load-f0-p0 stops after phase 0, load-f0
// after the frequency 0 halves. Raw write sends its word, control-set sends
// 0x2328 or 0x2308 per square_enable, and func codes 5 to 7 are accepted and
// produce nothing. The frequency and phase words are apb registers at byte
// addresses 0x0, 0x4, 0x8 and 0xC, read live by the sequencer, so write them
// only while no command is in flight. An intake stage classifies each
// transaction into a two-entry queue; the sequencer takes one entry,
// fetches it into its command register, then sends one item per cycle
// while the sink keeps taking them, and stalls while the sink holds off.
// The sequencer's step counter sets that rate; the output register lets
// new commands queue up while a finished item waits.
module dds_register_load_sequencer_unit import drls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  drls_cmd_if.sink              cmd_i,
  drls_item_if.source           item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  drls_cfg_t   cfg;
  logic        push_valid;
  logic        push_ready;
  drls_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  drls_entry_t pop_entry;

  // configuration registers
  drls_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // intake and classification
  drls_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // decoupling queue
  drls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // item sequencer with output register
  drls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .item_o      (item_o)
  );

endmodule

@@ rtl/drls_regs.sv @@
// apb register file for the frequency and phase words
module drls_regs import drls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output drls_cfg_t             cfg_o
);

  drls_cfg_t  cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FREQ0:  cfg_q.freq0  <= pwdata[FREQ_W-1:0];
        REG_PHASE0: cfg_q.phase0 <= pwdata[PHASE_W-1:0];
        REG_FREQ1:  cfg_q.freq1  <= pwdata[FREQ_W-1:0];
        REG_PHASE1: cfg_q.phase1 <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FREQ0:  prdata = {{(APB_DATA_W-FREQ_W){1'b0}}, cfg_q.freq0};
      REG_PHASE0: prdata = {{(APB_DATA_W-PHASE_W){1'b0}}, cfg_q.phase0};
      REG_FREQ1:  prdata = {{(APB_DATA_W-FREQ_W){1'b0}}, cfg_q.freq1};
      REG_PHASE1: prdata = {{(APB_DATA_W-PHASE_W){1'b0}}, cfg_q.phase1};
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/drls_front.sv @@
// command intake: classifies each command into a queue entry
module drls_front import drls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  drls_cmd_if.sink     cmd_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output drls_entry_t  push_entry_o
);

  logic        valid_q;
  drls_entry_t entry_q;
  drls_entry_t entry_d;
  logic        known_d;
  logic        accept;

  assign cmd_i.ready  = !valid_q || push_ready_i;
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

  // unused codes are taken and dropped
  always_comb begin
    entry_d.op   = OP_SINGLE;
    entry_d.word = cmd_i.raw_word;
    known_d      = 1'b1;
    case (cmd_i.func)
      FUNC_LOAD_F0:   entry_d.op = OP_LOAD_F0;
      FUNC_LOAD_F0P0: entry_d.op = OP_LOAD_F0P0;
      FUNC_LOAD_ALL:  entry_d.op = OP_LOAD_ALL;
      FUNC_RAW:       entry_d.op = OP_SINGLE;
      FUNC_CTRL:      entry_d.word = cmd_i.square_enable ? CTRL_SQW_ON : CTRL_SQW_OFF;
      default:        known_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= known_d;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

@@ rtl/drls_queue.sv @@
// two-entry queue between intake and sequencer
module drls_queue import drls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  drls_entry_t  push_entry_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output drls_entry_t  pop_entry_o
);

  drls_entry_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ rtl/drls_back.sv @@
// sequencer: steps through the frame items of one command
module drls_back import drls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  drls_cfg_t    cfg_i,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  drls_entry_t  pop_entry_i,
  drls_item_if.source  item_o
);

  logic               busy_q;
  logic [STEP_W-1:0]  step_q;
  drls_entry_t        cur_q;
  logic               out_valid_q;
  drls_item_t         out_q;
  drls_item_t         item_d;
  logic               emit;

  assign pop_ready_o = !busy_q;
  assign emit        = busy_q && (!out_valid_q || item_o.ready);

  assign item_o.valid       = out_valid_q;
  assign item_o.word        = out_q.word;
  assign item_o.reset_pulse = out_q.reset_pulse;
  assign item_o.last        = out_q.last;

  always_comb begin
    item_d.reset_pulse = 1'b0;
    item_d.last        = 1'b0;
    case (step_q)
      3'd0: item_d.word = CTRL_SQW_OFF;
      3'd1: begin
        item_d.word        = '0;
        item_d.reset_pulse = 1'b1;
      end
      3'd2: item_d.word = TAG_FREQ0 | {2'b0, cfg_i.freq0[HALF_W-1:0]};
      3'd3: item_d.word = TAG_FREQ0 | {2'b0, cfg_i.freq0[FREQ_W-1:HALF_W]};
      3'd4: item_d.word = (cur_q.op == OP_LOAD_F0P0)
                          ? (TAG_PHASE0 | {4'b0, cfg_i.phase0})
                          : (TAG_FREQ1 | {2'b0, cfg_i.freq1[HALF_W-1:0]});
      3'd5: item_d.word = TAG_FREQ1 | {2'b0, cfg_i.freq1[FREQ_W-1:HALF_W]};
      3'd6: item_d.word = TAG_PHASE0 | {4'b0, cfg_i.phase0};
      3'd7: item_d.word = TAG_PHASE1 | {4'b0, cfg_i.phase1};
      default: item_d.word = '0;
    endcase
    case (cur_q.op)
      OP_LOAD_F0:   item_d.last = step_q == 3'd3;
      OP_LOAD_F0P0: item_d.last = step_q == 3'd4;
      OP_LOAD_ALL:  item_d.last = step_q == 3'd7;
      OP_SINGLE:    item_d.last = 1'b1;
      default:      item_d.last = 1'b1;
    endcase
    // a single-word command sends the word it carries
    if (cur_q.op == OP_SINGLE) begin
      item_d.word        = cur_q.word;
      item_d.reset_pulse = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_q && pop_valid_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (emit) begin
        if (item_d.last) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (item_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && pop_valid_i) begin
      cur_q <= pop_entry_i;
    end
    if (emit) begin
      out_q <= item_d;
    end
  end

endmodule

@@ test/drls_tb_pkg.sv @@
// frame ledger class: predicts the frame items of each command and checks them
package drls_tb_pkg;
  import drls_pkg::*;

  class frame_ledger;
    drls_cfg_t   regs;
    drls_item_t  pending[$];
    int unsigned faults;

    function new();
      regs    = '0;
      faults  = 0;
    endfunction

    // registers keep only their own width
    function void set_register(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_FREQ0:  regs.freq0  = value[FREQ_W-1:0];
        REG_PHASE0: regs.phase0 = value[PHASE_W-1:0];
        REG_FREQ1:  regs.freq1  = value[FREQ_W-1:0];
        REG_PHASE1: regs.phase1 = value[PHASE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    // expand one accepted command into its run of frame items
    function void note_command(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] raw,
                               logic sqw);
      drls_item_t run[$];
      case (func)
        FUNC_LOAD_F0, FUNC_LOAD_F0P0, FUNC_LOAD_ALL: begin
          run.push_back('{CTRL_SQW_OFF, 1'b0, 1'b0});
          run.push_back('{'0, 1'b1, 1'b0});
          run.push_back('{TAG_FREQ0 | {2'b00, regs.freq0[HALF_W-1:0]}, 1'b0, 1'b0});
          run.push_back('{TAG_FREQ0 | {2'b00, regs.freq0[FREQ_W-1:HALF_W]}, 1'b0, 1'b0});
          if (func == FUNC_LOAD_F0P0) begin
            run.push_back('{TAG_PHASE0 | {4'h0, regs.phase0}, 1'b0, 1'b0});
          end else if (func == FUNC_LOAD_ALL) begin
            run.push_back('{TAG_FREQ1 | {2'b00, regs.freq1[HALF_W-1:0]}, 1'b0, 1'b0});
            run.push_back('{TAG_FREQ1 | {2'b00, regs.freq1[FREQ_W-1:HALF_W]}, 1'b0, 1'b0});
            run.push_back('{TAG_PHASE0 | {4'h0, regs.phase0}, 1'b0, 1'b0});
            run.push_back('{TAG_PHASE1 | {4'h0, regs.phase1}, 1'b0, 1'b0});
          end
        end
        FUNC_RAW:  run.push_back('{raw, 1'b0, 1'b0});
        FUNC_CTRL: run.push_back('{sqw ? CTRL_SQW_ON : CTRL_SQW_OFF, 1'b0, 1'b0});
        default: ;
      endcase
      if (run.size() != 0) begin
        run[run.size()-1].last = 1'b1;
        foreach (run[i]) pending.push_back(run[i]);
      end
    endfunction

    function void check_frame(drls_item_t got);
      drls_item_t want;
      if (pending.size() == 0) begin
        faults++;
        $error("frame item with nothing pending: word %h reset_pulse %b last %b",
               got.word, got.reset_pulse, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.word !== want.word) begin
        faults++;
        $error("word: expected %h, got %h", want.word, got.word);
      end
      if (got.reset_pulse !== want.reset_pulse) begin
        faults++;
        $error("reset_pulse: expected %b, got %b", want.reset_pulse, got.reset_pulse);
      end
      if (got.last !== want.last) begin
        faults++;
        $error("last: expected %b, got %b", want.last, got.last);
      end
    endfunction
  endclass

endpackage

@@ test/tb.sv @@
// testbench for the dds register load sequencer: commands, apb registers, frame checks
module tb;
  import drls_pkg::*;
  import drls_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 43;
  localparam int unsigned BURST_LEN       = 12;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // no random stalls on either side while set
  bit steady_flow;
  // asks the frame sink for one long hold-off
  bit hold_sink;

  frame_ledger ledger = new();

  drls_cmd_if  cmd ();
  drls_item_if item ();

  dds_register_load_sequencer_unit i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd),
    .item_o  (item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // register value: zero, width max, all 32 bits set or random
  function automatic logic [APB_DATA_W-1:0] pick_reg_value(int unsigned width);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return (APB_DATA_W'(1) << width) - 1;
      2: return '1;
      default: return $urandom();
    endcase
  endfunction

  // apb write: setup phase, then access phase
  task automatic write_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_register(idx, value);
  endtask

  task automatic program_registers(input logic [APB_DATA_W-1:0] f0, p0, f1, p1);
    write_register(REG_FREQ0, f0);
    @(posedge clk);
    write_register(REG_PHASE0, p0);
    @(posedge clk);
    write_register(REG_FREQ1, f1);
    @(posedge clk);
    write_register(REG_PHASE1, p1);
    @(posedge clk);
  endtask

  // returns at the edge where the command transaction is taken
  task automatic offer_command(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] raw,
                               input logic sqw);
    cmd.valid         <= 1'b1;
    cmd.func          <= func;
    cmd.raw_word      <= raw;
    cmd.square_enable <= sqw;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic pause_command(input int unsigned cycles);
    if (cycles != 0) begin
      cmd.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // sender idles until every frame item is back, then lets ignored commands drain
  task automatic wait_until_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // command monitor feeds the ledger with the registers of that moment
  always @(posedge clk) begin
    if (rst_n && cmd.valid && cmd.ready) begin
      ledger.note_command(cmd.func, cmd.raw_word, cmd.square_enable);
    end
  end

  // frame monitor compares against the oldest pending item
  always @(posedge clk) begin
    if (rst_n && item.valid && item.ready) begin
      ledger.check_frame(drls_item_t'{item.word, item.reset_pulse, item.last});
    end
  end

  // frame sink: random ready runs, plus one long hold-off on request
  initial begin
    item.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        item.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        int unsigned gap;
        item.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        gap = pick_gap();
        if (gap != 0) begin
          item.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned     counted;
    logic [FUNC_W-1:0] func;

    rst_n             = 1'b0;
    cmd.valid         = 1'b0;
    cmd.func          = FUNC_LOAD_F0;
    cmd.raw_word      = '0;
    cmd.square_enable = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    steady_flow       = 1'b0;
    hold_sink         = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers straight out of reset
    offer_command(FUNC_LOAD_ALL, 16'hFFFF, 1'b1);
    wait_until_drained();

    // every bit set, oversized values must be cut to register width
    program_registers('1, '1, '1, '1);
    offer_command(FUNC_LOAD_F0, 16'h0000, 1'b0);
    pause_command(pick_gap());
    offer_command(FUNC_LOAD_F0P0, 16'hFFFF, 1'b1);
    pause_command(pick_gap());
    offer_command(FUNC_LOAD_ALL, 16'h0000, 1'b1);
    wait_until_drained();

    // alternating patterns keep the halves and tags apart
    program_registers(32'h0AAA_AAAA, 32'h0000_0555, 32'h0555_5555, 32'h0000_0AAA);
    offer_command(FUNC_LOAD_ALL, 16'h1234, 1'b0);
    offer_command(FUNC_LOAD_F0P0, 16'h0000, 1'b0);
    offer_command(FUNC_RAW, 16'h0000, 1'b1);
    offer_command(FUNC_RAW, 16'hFFFF, 1'b0);
    offer_command(FUNC_CTRL, 16'hFFFF, 1'b0);
    offer_command(FUNC_CTRL, 16'h0000, 1'b1);
    // unused codes produce nothing
    offer_command(3'd5, 16'hFFFF, 1'b1);
    offer_command(3'd6, 16'h0000, 1'b0);
    offer_command(3'd7, 16'hA5A5, 1'b1);
    offer_command(FUNC_RAW, 16'h8001, 1'b1);
    wait_until_drained();

    program_registers('0, '0, '0, '0);
    offer_command(FUNC_LOAD_ALL, 16'hFFFF, 1'b1);
    offer_command(FUNC_LOAD_F0, 16'hFFFF, 1'b1);
    wait_until_drained();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      program_registers(pick_reg_value(FREQ_W), pick_reg_value(PHASE_W),
                        pick_reg_value(FREQ_W), pick_reg_value(PHASE_W));
      steady_flow = (phase == 1);

      if (phase == 3) begin
        // sink holds off while load-all commands keep coming until intake stalls
        hold_sink = 1'b1;
        for (int unsigned n = 0; n < BURST_LEN; n++) begin
          offer_command(FUNC_LOAD_ALL, WORD_W'($urandom()), 1'($urandom()));
        end
        wait_until_drained();
      end

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        func = FUNC_W'($urandom_range(0, 7));
        // keep the ignored codes to roughly one in eight
        if (func > FUNC_CTRL && $urandom_range(0, 2) != 0) func = FUNC_W'($urandom_range(0, 4));
        offer_command(func, WORD_W'($urandom()), 1'($urandom()));
        if (func <= FUNC_CTRL) counted++;
        pause_command(pick_gap());
      end
      wait_until_drained();
    end

    if (ledger.faults == 0 && ledger.outstanding() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #12_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
